FILE: rtl/mieu_pkg.sv
// Shared types and constants for the integer execute unit.
// Depends on nothing; used by every module in rtl/.
package mieu_pkg;

	localparam logic [2:0] EXC_NONE     = 3'd0;
	localparam logic [2:0] EXC_OVERFLOW = 3'd1;
	localparam logic [2:0] EXC_SYSCALL  = 3'd2;
	localparam logic [2:0] EXC_BREAK    = 3'd3;
	localparam logic [2:0] EXC_RESERVED = 3'd4;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;

	// Branches, jumps, coprocessor ops, loads and stores: no effect here
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_COP0    = 6'h10;
	localparam logic [5:0] OP_COP1    = 6'h11;
	localparam logic [5:0] OP_COP2    = 6'h12;
	localparam logic [5:0] OP_COP3    = 6'h13;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LWL     = 6'h22;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_LWR     = 6'h26;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SWL     = 6'h2A;
	localparam logic [5:0] OP_SW      = 6'h2B;
	localparam logic [5:0] OP_SWR     = 6'h2E;
	localparam logic [5:0] OP_LWC0    = 6'h30;
	localparam logic [5:0] OP_LWC1    = 6'h31;
	localparam logic [5:0] OP_LWC2    = 6'h32;
	localparam logic [5:0] OP_LWC3    = 6'h33;
	localparam logic [5:0] OP_SWC0    = 6'h38;
	localparam logic [5:0] OP_SWC1    = 6'h39;
	localparam logic [5:0] OP_SWC2    = 6'h3A;
	localparam logic [5:0] OP_SWC3    = 6'h3B;

	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_BREAK   = 6'h0D;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	// Long-running hi/lo operation request
	typedef enum logic [1:0] {
		MD_MULT  = 2'd0,
		MD_MULTU = 2'd1,
		MD_DIV   = 2'd2,
		MD_DIVU  = 2'd3
	} md_op_t;

	typedef struct packed {
		logic        start;
		md_op_t      op;
		logic [31:0] a;
		logic [31:0] b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic        upd;
		logic [31:0] hi;
		logic [31:0] lo;
	} md_rsp_t;

	// Result of one instruction
	typedef struct packed {
		logic [2:0]  exc;
		logic        we;
		logic [4:0]  widx;
		logic [31:0] wval;
	} alu_res_t;

endpackage

FILE: rtl/mips_integer_execute_unit_top.sv
// Top level of the integer execute unit: register file memory, hi/lo,
// sequencer and output register. Depends on mieu_pkg, mieu_alu, mieu_muldiv.

// One instruction per transfer, one result per instruction. Both operands are
// read from the synchronous register file at the input transfer; an ALU
// instruction executes, writes back and loads the output register in the
// next cycle, and the output state then marks its result valid.
// MULT/MULTU/DIV/DIVU occupy the shared one-bit-per-cycle multiply/divide
// unit for 32 iterations and wait for its done signal before the output
// state; the next instruction is taken only once the result is valid. A
// result that waits on the output holds off the next instruction. After reset
// a clearing pass zeroes the register file; no instruction is taken during it.
module mips_integer_execute_unit_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] instruction
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata    // [2:0] exception_code, [3] write_enable,
	                                // [8:4] write_index, [40:9] write_value,
	                                // [72:41] hi_value, [104:73] lo_value,
	                                // [111:105] zero
);
	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_EXE  = 5'b00100,
		ST_MD   = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [4:0]         clr_q;
	logic [31:0]        rf [32];
	logic [31:0]        rda_q, rdb_q, ins_q, hi_q, lo_q;
	mieu_pkg::alu_res_t res, res_q;
	logic               mthi, mtlo, md_start, ovalid_q;
	mieu_pkg::md_op_t   md_op;
	mieu_pkg::md_req_t  req;
	mieu_pkg::md_rsp_t  rsp;
	logic               s_acc, o_free;
	logic [31:0]        a, b;

	assign o_free   = !ovalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && o_free;
	assign s_acc    = s_tvalid && s_tready;

	// Register 0 reads zero regardless of memory contents
	assign a = (ins_q[25:21] == 5'd0) ? 32'd0 : rda_q;
	assign b = (ins_q[20:16] == 5'd0) ? 32'd0 : rdb_q;

	mieu_alu u_alu (
		.ins(ins_q), .a(a), .b(b), .hi(hi_q), .lo(lo_q), .res(res),
		.mthi(mthi), .mtlo(mtlo), .md_start(md_start), .md_op(md_op)
	);

	always_comb begin
		req.start = (state_q == ST_EXE) && md_start;
		req.op    = md_op;
		req.a     = a;
		req.b     = b;
	end

	mieu_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// Register file: read on accept, write in execute or clearing pass
	always_ff @(posedge clk) begin
		if (s_acc) begin
			rda_q <= rf[s_tdata[25:21]];
			rdb_q <= rf[s_tdata[20:16]];
			ins_q <= s_tdata;
		end
		if (state_q == ST_CLR) begin
			rf[clr_q] <= '0;
		end else if ((state_q == ST_EXE) && res.we) begin
			rf[res.widx] <= res.wval;
		end
	end

	// Sequencer, hi/lo and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			hi_q     <= '0;
			lo_q     <= '0;
			res_q    <= '0;
		end else begin
			if (m_tvalid && m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 5'd1;
					if (clr_q == 5'd31) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_acc) state_q <= ST_EXE;
				ST_EXE: begin
					res_q <= res;
					if (mthi) hi_q <= a;
					if (mtlo) lo_q <= a;
					state_q <= md_start ? ST_MD : ST_OUT;
				end
				ST_MD: if (rsp.done) begin
					if (rsp.upd) begin
						hi_q <= rsp.hi;
						lo_q <= rsp.lo;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {7'd0, lo_q, hi_q, res_q.wval, res_q.widx, res_q.we, res_q.exc};

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input accepted while busy");
	a_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3] == (m_tdata[8:4] != 5'd0)))
		else $error("write enable inconsistent with index");
	a_exc_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:0] != mieu_pkg::EXC_NONE)) |-> !m_tdata[3])
		else $error("write on exception");
endmodule

FILE: rtl/mieu_alu.sv
// Combinational decode and integer ALU for one instruction.
// Depends on mieu_pkg.
module mieu_alu (
	input  logic [31:0]        ins,
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  logic [31:0]        hi,
	input  logic [31:0]        lo,
	output mieu_pkg::alu_res_t res,
	output logic               mthi,
	output logic               mtlo,
	output logic               md_start,
	output mieu_pkg::md_op_t   md_op
);
	logic [5:0]  op, fn;
	logic [4:0]  sh;
	logic [31:0] se, ze, sum, dif, asum;
	logic        wr;

	assign op = ins[31:26];
	assign fn = ins[5:0];
	assign sh = ins[10:6];
	assign se = {{16{ins[15]}}, ins[15:0]};
	assign ze = {16'd0, ins[15:0]};
	assign sum = a + b;
	assign dif = a - b;
	assign asum = a + se;

	// Decode and compute the register write
	always_comb begin
		res.exc  = mieu_pkg::EXC_NONE;
		res.wval = '0;
		wr       = 1'b1;
		mthi     = 1'b0;
		mtlo     = 1'b0;
		md_start = 1'b0;
		md_op    = mieu_pkg::MD_MULT;
		res.widx = (op == mieu_pkg::OP_SPECIAL) ? ins[15:11] : ins[20:16];
		if (op == mieu_pkg::OP_SPECIAL) begin
			unique case (fn) inside
				mieu_pkg::FN_SLL:  res.wval = b << sh;
				mieu_pkg::FN_SRL:  res.wval = b >> sh;
				mieu_pkg::FN_SRA:  res.wval = $signed(b) >>> sh;
				mieu_pkg::FN_SLLV: res.wval = b << a[4:0];
				mieu_pkg::FN_SRLV: res.wval = b >> a[4:0];
				mieu_pkg::FN_SRAV: res.wval = $signed(b) >>> a[4:0];
				mieu_pkg::FN_JR, mieu_pkg::FN_JALR: wr = 1'b0;
				mieu_pkg::FN_SYSCALL: begin
					wr = 1'b0; res.exc = mieu_pkg::EXC_SYSCALL;
				end
				mieu_pkg::FN_BREAK: begin
					wr = 1'b0; res.exc = mieu_pkg::EXC_BREAK;
				end
				mieu_pkg::FN_MFHI: res.wval = hi;
				mieu_pkg::FN_MTHI: begin wr = 1'b0; mthi = 1'b1; end
				mieu_pkg::FN_MFLO: res.wval = lo;
				mieu_pkg::FN_MTLO: begin wr = 1'b0; mtlo = 1'b1; end
				mieu_pkg::FN_MULT: begin
					wr = 1'b0; md_start = 1'b1; md_op = mieu_pkg::MD_MULT;
				end
				mieu_pkg::FN_MULTU: begin
					wr = 1'b0; md_start = 1'b1; md_op = mieu_pkg::MD_MULTU;
				end
				mieu_pkg::FN_DIV: begin
					wr = 1'b0; md_start = 1'b1; md_op = mieu_pkg::MD_DIV;
				end
				mieu_pkg::FN_DIVU: begin
					wr = 1'b0; md_start = 1'b1; md_op = mieu_pkg::MD_DIVU;
				end
				mieu_pkg::FN_ADD: begin
					res.wval = sum;
					if ((a[31] == b[31]) && (sum[31] != a[31])) begin
						wr = 1'b0; res.exc = mieu_pkg::EXC_OVERFLOW;
					end
				end
				mieu_pkg::FN_ADDU: res.wval = sum;
				mieu_pkg::FN_SUB: begin
					res.wval = dif;
					if ((a[31] != b[31]) && (dif[31] != a[31])) begin
						wr = 1'b0; res.exc = mieu_pkg::EXC_OVERFLOW;
					end
				end
				mieu_pkg::FN_SUBU: res.wval = dif;
				mieu_pkg::FN_AND:  res.wval = a & b;
				mieu_pkg::FN_OR:   res.wval = a | b;
				mieu_pkg::FN_XOR:  res.wval = a ^ b;
				mieu_pkg::FN_NOR:  res.wval = ~(a | b);
				mieu_pkg::FN_SLT:  res.wval = {31'd0, $signed(a) < $signed(b)};
				mieu_pkg::FN_SLTU: res.wval = {31'd0, a < b};
				default: begin wr = 1'b0; res.exc = mieu_pkg::EXC_RESERVED; end
			endcase
		end else begin
			unique case (op) inside
				mieu_pkg::OP_ADDI: begin
					res.wval = asum;
					if ((a[31] == se[31]) && (asum[31] != a[31])) begin
						wr = 1'b0; res.exc = mieu_pkg::EXC_OVERFLOW;
					end
				end
				mieu_pkg::OP_ADDIU: res.wval = asum;
				mieu_pkg::OP_SLTI:  res.wval = {31'd0, $signed(a) < $signed(se)};
				mieu_pkg::OP_SLTIU: res.wval = {31'd0, a < se};
				mieu_pkg::OP_ANDI:  res.wval = a & ze;
				mieu_pkg::OP_ORI:   res.wval = a | ze;
				mieu_pkg::OP_XORI:  res.wval = a ^ ze;
				mieu_pkg::OP_LUI:   res.wval = {ins[15:0], 16'd0};
				mieu_pkg::OP_REGIMM, mieu_pkg::OP_J, mieu_pkg::OP_JAL,
				mieu_pkg::OP_BEQ, mieu_pkg::OP_BNE, mieu_pkg::OP_BLEZ,
				mieu_pkg::OP_BGTZ,
				mieu_pkg::OP_COP0, mieu_pkg::OP_COP1, mieu_pkg::OP_COP2,
				mieu_pkg::OP_COP3,
				mieu_pkg::OP_LB, mieu_pkg::OP_LH, mieu_pkg::OP_LWL,
				mieu_pkg::OP_LW, mieu_pkg::OP_LBU, mieu_pkg::OP_LHU,
				mieu_pkg::OP_LWR,
				mieu_pkg::OP_SB, mieu_pkg::OP_SH, mieu_pkg::OP_SWL,
				mieu_pkg::OP_SW, mieu_pkg::OP_SWR,
				mieu_pkg::OP_LWC0, mieu_pkg::OP_LWC1, mieu_pkg::OP_LWC2,
				mieu_pkg::OP_LWC3,
				mieu_pkg::OP_SWC0, mieu_pkg::OP_SWC1, mieu_pkg::OP_SWC2,
				mieu_pkg::OP_SWC3: wr = 1'b0;
				default: begin wr = 1'b0; res.exc = mieu_pkg::EXC_RESERVED; end
			endcase
		end
		res.we = wr && (res.widx != 5'd0);
		if (!res.we) begin
			res.widx = '0;
			res.wval = '0;
		end
	end
endmodule

FILE: rtl/mieu_muldiv.sv
// Shared multi-cycle multiply/divide unit: radix-2 shift-add multiply and
// restoring divide on magnitudes, one bit per cycle. Depends on mieu_pkg.
module mieu_muldiv (
	input  logic               clk,
	input  logic               arst_n,
	input  mieu_pkg::md_req_t  req,
	output mieu_pkg::md_rsp_t  rsp
);
	logic        busy_q, div_q, neg_q_q, neg_r_q, upd_q;
	logic [5:0]  cnt_q;
	logic [31:0] acc_q, x_q, y_q;
	logic [32:0] trial;
	logic        sa, sb, is_div, sgn;
	logic [31:0] ma, mb;
	logic [63:0] raw, prod;
	logic [31:0] quo, rem;

	always_comb begin
		is_div = (req.op == mieu_pkg::MD_DIV) || (req.op == mieu_pkg::MD_DIVU);
		sgn    = (req.op == mieu_pkg::MD_MULT) || (req.op == mieu_pkg::MD_DIV);
		sa     = sgn & req.a[31];
		sb     = sgn & req.b[31];
		ma     = sa ? (~req.a + 32'd1) : req.a;
		mb     = sb ? (~req.b + 32'd1) : req.b;
	end

	// multiply: acc:x hold partial product; divide: acc remainder, x quotient
	assign trial = div_q ? ({acc_q, x_q[31]} - {1'b0, y_q})
	                     : ({1'b0, acc_q} + (x_q[0] ? {1'b0, y_q} : 33'd0));

	// Count 32 iterations, then hold one done cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			if (cnt_q != 6'd0) cnt_q <= cnt_q - 6'd1;
			else busy_q <= 1'b0;
		end
	end

	// Advance one bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q   <= is_div;
			neg_q_q <= sa ^ sb;
			neg_r_q <= sa;
			upd_q   <= !(is_div && (req.b == 32'd0));
			acc_q   <= '0;
			x_q     <= ma;
			y_q     <= mb;
		end else if (busy_q && (cnt_q != 6'd0)) begin
			if (div_q) begin
				if (!trial[32]) begin
					acc_q <= trial[31:0];
					x_q   <= {x_q[30:0], 1'b1};
				end else begin
					acc_q <= {acc_q[30:0], x_q[31]};
					x_q   <= {x_q[30:0], 1'b0};
				end
			end else begin
				acc_q <= trial[32:1];
				x_q   <= {trial[0], x_q[31:1]};
			end
		end
	end

	assign raw  = {acc_q, x_q};
	assign prod = neg_q_q ? (~raw + 64'd1) : raw;
	assign quo  = neg_q_q ? (~x_q + 32'd1) : x_q;
	assign rem  = neg_r_q ? (~acc_q + 32'd1) : acc_q;

	always_comb begin
		rsp.done = busy_q && (cnt_q == 6'd0);
		rsp.upd  = upd_q;
		rsp.hi   = div_q ? rem : prod[63:32];
		rsp.lo   = div_q ? quo : prod[31:0];
	end
endmodule
